### design/bcfs_pkg.sv
// Bunch charge feedback package: widths, status codes, shared types.
// No dependencies.
`default_nettype none
package bcfs_pkg;
	localparam int AVG_WINDOW_DEF     = 10;
	localparam int GOOD_TARGET_DEF    = 10;
	localparam int SKIP_LIMIT_DEF     = 5;
	localparam int MISMATCH_LIMIT_DEF = 10;

	localparam logic [31:0] CHARGE_PER_E = 32'd11543627;
	localparam logic [7:0]  POS_LOW      = 8'd10;
	localparam logic [7:0]  POS_HIGH     = 8'd18;

	typedef enum logic [3:0] {
		ST_AVERAGING = 4'd0, ST_ACTED = 4'd1, ST_MOVING = 4'd2, ST_LOW = 4'd3,
		ST_MISMATCH = 4'd4, ST_MISMATCH_LIMIT = 4'd5, ST_SKIP = 4'd6,
		ST_LASER_FAULT = 4'd7, ST_CAMERA_FAULT = 4'd8, ST_BOTH_FAULT = 4'd9,
		ST_RANGE = 4'd10
	} status_t;

	typedef enum logic [2:0] {
		REG_TMIT_LOW = 3'd0, REG_SETPOINT = 3'd1, REG_GAIN = 3'd2, REG_MODE = 3'd3,
		REG_ACT_MIN = 3'd4, REG_ACT_MAX = 3'd5, REG_ACT_INIT = 3'd6
	} reg_idx_t;

	// Datapath operations.
	typedef enum logic [3:0] {
		OP_NONE, OP_FRONT, OP_DIV, OP_CHARGE, OP_ERR, OP_CORR, OP_CLAMP,
		OP_FACT, OP_MUL, OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic act;     // front step wants to compute an actuator value
		logic div_busy;
		logic corr_big;
	} dp_sts_t;

	typedef struct packed {
		logic [3:0]  step_status;
		logic [31:0] actuator_value;
		logic [31:0] charge_state;
		logic        actuator_written;
	} result_t;

	typedef struct packed {
		logic        laser_done;
		logic        camera_done;
		logic [7:0]  laser_position;
		logic [7:0]  camera_position;
		logic        pulse_match;
		logic [35:0] electron_count;
		logic        recheck_laser_done;
		logic        recheck_camera_done;
		logic [7:0]  recheck_laser_position;
		logic [7:0]  recheck_camera_position;
	} item_t;

	function automatic logic settled(logic ld, logic cd, logic [7:0] lp, logic [7:0] cp);
		settled = ld && cd && lp >= POS_LOW && lp <= POS_HIGH &&
			cp >= POS_LOW && cp <= POS_HIGH;
	endfunction
endpackage
`default_nettype wire

### design/bcfs_stream_if.sv
// Valid/ready channel carrying one item of type T.
// Depends on nothing; payload type set by the user.
`default_nettype none
interface bcfs_stream_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/bcfs_ctrl.sv
// Controller for the feedback step: sequences datapath operations.
// Depends on bcfs_pkg.
`default_nettype none
module bcfs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bcfs_pkg::dp_cmd_t       cmd,
	input  wire bcfs_pkg::dp_sts_t  sts
);
	import bcfs_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001, S_DIV = 10'b0000000010, S_CHG = 10'b0000000100,
		S_ERR = 10'b0000001000, S_CORR = 10'b0000010000, S_CLMP = 10'b0000100000,
		S_FACT = 10'b0001000000, S_MUL = 10'b0010000000, S_FIN = 10'b0100000000,
		S_OUT = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// Next state and command.
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_FRONT;
					state_d = sts.act ? S_DIV : S_OUT;
				end
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (!sts.div_busy) state_d = S_CHG;
			end
			S_CHG:  begin cmd.op = OP_CHARGE; state_d = S_ERR; end
			S_ERR:  begin cmd.op = OP_ERR; state_d = S_CORR; end
			S_CORR: begin
				cmd.op = OP_CORR;
				state_d = S_CLMP;
			end
			S_CLMP: begin cmd.op = OP_CLAMP; state_d = S_FACT; end
			S_FACT: begin cmd.op = OP_FACT; state_d = S_MUL; end
			S_MUL:  begin cmd.op = OP_MUL; state_d = S_FIN; end
			S_FIN:  begin cmd.op = OP_FINISH; state_d = S_OUT; end
			S_OUT:  begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

### design/bcfs_datapath.sv
// Datapath: window, counters, serial divider, charge and actuator math.
// Depends on bcfs_pkg.
`default_nettype none
module bcfs_datapath #(
	parameter int AVG_WINDOW     = bcfs_pkg::AVG_WINDOW_DEF,
	parameter int GOOD_TARGET    = bcfs_pkg::GOOD_TARGET_DEF,
	parameter int SKIP_LIMIT     = bcfs_pkg::SKIP_LIMIT_DEF,
	parameter int MISMATCH_LIMIT = bcfs_pkg::MISMATCH_LIMIT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [35:0]        cfg_data,
	input  wire bcfs_pkg::item_t    item,
	input  wire bcfs_pkg::dp_cmd_t  cmd,
	output bcfs_pkg::dp_sts_t       sts,
	output bcfs_pkg::result_t       res
);
	import bcfs_pkg::*;

	localparam int IW = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
	localparam int FW = $clog2(AVG_WINDOW + 1);
	localparam int SW = 36 + FW;
	localparam logic [IW-1:0] LAST_IDX = IW'(AVG_WINDOW - 1);
	localparam logic [FW-1:0] FULL     = FW'(AVG_WINDOW);
	localparam logic [7:0] GOOD_T = 8'(GOOD_TARGET);
	localparam logic [7:0] SKIP_L = 8'(SKIP_LIMIT);
	localparam logic [7:0] MISM_L = 8'(MISMATCH_LIMIT);
	localparam logic signed [65:0] ONE24 = 66'sd16777216;

	// Configuration registers.
	logic [35:0] tmit_low_q;
	logic [31:0] setpoint_q, gain_q, act_min_q, act_max_q;
	logic        mode_q;

	// Step state.
	logic [35:0]   win_mem [AVG_WINDOW];
	logic [FW-1:0] fill_q;
	logic [SW-1:0] sum_q;
	logic [IW-1:0] head_q;
	logic [7:0]    good_q, skip_q, mism_q;
	logic [31:0]   held_q, charge_q;
	logic [3:0]    status_q;
	logic          written_q;

	// Work registers.
	logic [SW-1:0]        rem_q, quo_q;
	logic [5:0]           bit_q;
	logic                 div_run_q;
	logic signed [65:0]   corr_q;
	logic signed [65:0]   fact_q;
	logic [63:0]          val_q;
	logic                 bad_q;

	// Front step decisions.
	logic        ok1, ok2, is_good;
	logic [7:0]  good_n, mism_n;
	logic [35:0] old_v;
	assign ok1     = settled(item.laser_done, item.camera_done,
		item.laser_position, item.camera_position);
	assign ok2     = settled(item.recheck_laser_done, item.recheck_camera_done,
		item.recheck_laser_position, item.recheck_camera_position);
	assign is_good = item.electron_count > tmit_low_q;
	assign good_n  = (is_good && good_q != 8'hFF) ? good_q + 8'd1 : good_q;
	assign mism_n  = (mism_q != 8'hFF) ? mism_q + 8'd1 : mism_q;
	assign old_v   = win_mem[head_q];

	// The item on the input decides at once whether the long sequence runs.
	assign sts.act      = ok1 && item.pulse_match && (good_n >= GOOD_T) && ok2;
	assign sts.div_busy = div_run_q;
	assign sts.corr_big = (corr_q > ONE24);

	assign res.step_status      = status_q;
	assign res.actuator_value   = held_q;
	assign res.charge_state     = charge_q;
	assign res.actuator_written = written_q;

	// Divider trial subtract.
	logic [SW:0] trial;
	assign trial = {rem_q[SW-2:0], quo_q[SW-1]} - {{(SW+1-FW){1'b0}}, fill_q};
	logic [SW-1:0] rem_sh;
	assign rem_sh = {rem_q[SW-2:0], quo_q[SW-1]};

	// Arithmetic for each operation.
	logic [SW+31:0]     prod_c;
	logic [SW+31:0]     q_c;
	logic signed [65:0] err_s, gain_s, ec;
	logic [65:0]        c_u;
	logic [65:0]        big_c;
	logic [65:0]        lo_p;
	logic [63:0]        f_u;
	logic [63:0]        mul_v;
	logic [31:0]        nv_c;
	assign prod_c = {32'd0, quo_q} * {{SW{1'b0}}, CHARGE_PER_E};
	assign q_c    = (prod_c + (SW+32)'(64'h80000000)) >> 32;
	assign err_s  = $signed({34'd0, charge_q}) - $signed({34'd0, setpoint_q});
	assign gain_s = {{34{gain_q[31]}}, gain_q};
	assign ec     = err_s * gain_s + 66'sd8388608;
	assign c_u    = corr_q;
	// A positive correction stays below 2^39, so its integer part fits 16 bits.
	assign big_c  = {50'd0, c_u[39:24]} * {34'd0, setpoint_q};
	assign lo_p   = {42'd0, c_u[23:0]} * {34'd0, setpoint_q} + 66'd8388608;
	assign f_u    = fact_q[63:0];
	// Integer part of the factor is below 2^32 whenever the product is used.
	assign mul_v  = {32'd0, held_q} * {32'd0, f_u[55:24]} +
		(({32'd0, held_q} * {40'd0, f_u[23:0]} + 64'd8388608) >> 24);
	// Mode 0 applies the held value again.
	assign nv_c   = mode_q ? val_q[31:0] : held_q;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FRONT && ok1 && item.pulse_match && is_good)
			win_mem[head_q] <= item.electron_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmit_low_q <= '0; setpoint_q <= '0; gain_q <= '0; mode_q <= 1'b0;
			act_min_q <= '0; act_max_q <= '1; held_q <= '0;
			fill_q <= '0; sum_q <= '0; head_q <= '0;
			good_q <= '0; skip_q <= '0; mism_q <= '0; charge_q <= '0;
			status_q <= ST_AVERAGING; written_q <= 1'b0;
			div_run_q <= 1'b0; bit_q <= '0;
			rem_q <= '0; quo_q <= '0; corr_q <= '0; fact_q <= '0;
			val_q <= '0; bad_q <= 1'b0;
		end else begin
			// Register writes.
			if (cfg_we) begin
				case (cfg_index)
					REG_TMIT_LOW: tmit_low_q <= cfg_data;
					REG_SETPOINT: setpoint_q <= cfg_data[31:0];
					REG_GAIN:     gain_q     <= cfg_data[31:0];
					REG_MODE:     mode_q     <= cfg_data[0];
					REG_ACT_MIN:  act_min_q  <= cfg_data[31:0];
					REG_ACT_MAX:  act_max_q  <= cfg_data[31:0];
					REG_ACT_INIT: held_q     <= cfg_data[31:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_FRONT: begin
					written_q <= 1'b0;
					if (!ok1) begin
						good_q <= '0; status_q <= ST_MOVING;
					end else if (!item.pulse_match) begin
						if (mism_n >= MISM_L) begin
							mism_q <= '0; status_q <= ST_MISMATCH_LIMIT;
						end else begin
							mism_q <= mism_n; status_q <= ST_MISMATCH;
						end
					end else begin
						mism_q <= '0;
						// Advance the window when the reading counts.
						if (is_good) begin
							if (fill_q >= FULL) sum_q <= sum_q - SW'(old_v) + SW'(item.electron_count);
							else begin
								fill_q <= fill_q + 1'b1;
								sum_q  <= sum_q + SW'(item.electron_count);
							end
							head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
						end
						if (good_n >= GOOD_T) begin
							good_q <= '0;
							if (!ok2) begin
								// Skip: clear the window, count, classify.
								skip_q <= (skip_q != 8'hFF) ? skip_q + 8'd1 : skip_q;
								fill_q <= '0; sum_q <= '0; head_q <= '0;
								status_q <= ST_SKIP;
								if (((skip_q != 8'hFF) ? skip_q + 8'd1 : skip_q) >= SKIP_L) begin
									if (!item.recheck_laser_done && item.recheck_camera_done)
										status_q <= ST_LASER_FAULT;
									else if (item.recheck_laser_done && !item.recheck_camera_done)
										status_q <= ST_CAMERA_FAULT;
									else if (!item.recheck_laser_done && !item.recheck_camera_done)
										status_q <= ST_BOTH_FAULT;
								end
							end
						end else begin
							good_q   <= good_n;
							status_q <= is_good ? ST_AVERAGING : ST_LOW;
						end
					end
					// Prime the divider: numerator in quo, shifted out MSB first.
					quo_q     <= is_good ? ((fill_q >= FULL) ? sum_q - SW'(old_v) +
						SW'(item.electron_count) : sum_q + SW'(item.electron_count)) : sum_q;
					rem_q     <= '0;
					bit_q     <= 6'(SW);
					div_run_q <= 1'b1;
				end
				OP_DIV: begin
					// One quotient bit per cycle, restoring division.
					if (div_run_q) begin
						if (!trial[SW]) begin
							rem_q <= trial[SW-1:0];
							quo_q <= {quo_q[SW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[SW-2:0], 1'b0};
						end
						bit_q <= bit_q - 6'd1;
						if (bit_q == 6'd1) div_run_q <= 1'b0;
					end
				end
				OP_CHARGE: charge_q <= (q_c[SW+31:32] != '0) ? 32'hFFFFFFFF : q_c[31:0];
				OP_ERR:   corr_q <= ec >>> 24;
				OP_CORR:  if (sts.corr_big) corr_q <= $signed(big_c + (lo_p >> 24));
				OP_CLAMP: fact_q <= ONE24 - corr_q;
				OP_FACT: begin
					if (fact_q <= 0 || held_q == '0) begin
						val_q <= '0;
						bad_q <= (fact_q < 0 && held_q != '0);
					end else bad_q <= (f_u[63:56] != '0);
				end
				OP_MUL: begin
					if (!bad_q && fact_q > 0 && held_q != '0) begin
						val_q <= mul_v;
						if (mul_v[63:32] != '0) bad_q <= 1'b1;
					end
				end
				OP_FINISH: begin
					if ((!mode_q || !bad_q) && nv_c >= act_min_q && nv_c <= act_max_q) begin
						held_q <= nv_c;
						written_q <= 1'b1; skip_q <= '0; status_q <= ST_ACTED;
					end else status_q <= ST_RANGE;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/bunch_charge_feedback_step.sv
// Top level of the bunch charge feedback step: controller plus datapath.
// Depends on bcfs_pkg, bcfs_stream_if, bcfs_ctrl, bcfs_datapath.
//
//  channel  | dir | payload
//  in_ch    | in  | item_t: waveplate reads, pulse match, electron count, recheck
//  out_ch   | out | result_t: status, actuator value, charge, written flag
//  cfg_*    | in  | register index and data, write only
//
// An item that does not act goes straight to the output; one that acts runs
// through the bit-serial divider (one quotient bit per cycle over the 40-bit
// sum of the default window) and the seven charge/correction/multiply steps.
// Reset clears counters, window and registers. The result waits in the output
// register until taken.
`default_nettype none
module bunch_charge_feedback_step #(
	parameter int AVG_WINDOW     = bcfs_pkg::AVG_WINDOW_DEF,
	parameter int GOOD_TARGET    = bcfs_pkg::GOOD_TARGET_DEF,
	parameter int SKIP_LIMIT     = bcfs_pkg::SKIP_LIMIT_DEF,
	parameter int MISMATCH_LIMIT = bcfs_pkg::MISMATCH_LIMIT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [35:0] cfg_data,
	bcfs_stream_if.sink      in_ch,
	bcfs_stream_if.source    out_ch
);
	import bcfs_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	bcfs_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd, .sts
	);

	bcfs_datapath #(
		.AVG_WINDOW(AVG_WINDOW), .GOOD_TARGET(GOOD_TARGET),
		.SKIP_LIMIT(SKIP_LIMIT), .MISMATCH_LIMIT(MISMATCH_LIMIT)
	) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.item(in_ch.data), .cmd, .sts, .res(out_ch.data)
	);
endmodule
`default_nettype wire

### design/bcfs_checker.sv
// Port-level checks for the feedback step, bound to the top level.
// Depends on bcfs_pkg.
`default_nettype none
module bcfs_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire bcfs_pkg::result_t res
);
	import bcfs_pkg::*;

	// One item at a time: no input taken while a result is shown.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	// A result follows an accepted item.
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_ready) else $error("result without item");
	// Written flag only with acted status.
	a_written: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res.actuator_written |-> res.step_status == ST_ACTED)
		else $error("written without acted");
	// Status code range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> res.step_status <= ST_RANGE) else $error("bad status");
	// Stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res)) else $error("result dropped");
endmodule

bind bunch_charge_feedback_step bcfs_checker u_chk (
	.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.res(out_ch.data)
);
`default_nettype wire

### test/tb_bunch_charge_feedback_step.sv
// Testbench for bunch_charge_feedback_step: random and directed beam pulses,
// a bit-exact predictor of status, actuator value and charge, and a result checker.
// Depends on bcfs_pkg, bcfs_stream_if and the block itself.
`timescale 1ns / 100ps
`default_nettype none
module tb_bunch_charge_feedback_step;
	import bcfs_pkg::*;

	localparam int WIN = AVG_WINDOW_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [35:0] cfg_data = '0;

	bcfs_stream_if #(.T(item_t)) in_ch (clk);
	bcfs_stream_if #(.T(result_t)) out_ch (clk);

	bunch_charge_feedback_step uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor registers and state
	logic [35:0] p_tmit_low;
	logic [31:0] p_setpoint, p_gain, p_act_min, p_act_max;
	logic p_mode;
	logic [35:0] p_window [WIN];
	int unsigned p_fill, p_head, p_good, p_skip, p_mism;
	logic [39:0] p_sum;
	logic [31:0] p_held, p_charge;

	item_t pending_items [$];
	result_t expected_results [$];
	int errors = 0;

	function automatic void clear_window();
		for (int i = 0; i < WIN; i++) p_window[i] = '0;
		p_fill = 0;
		p_sum = '0;
		p_head = 0;
	endfunction

	function automatic void reset_predictor();
		p_tmit_low = '0; p_setpoint = '0; p_gain = '0; p_mode = 1'b0;
		p_act_min = '0; p_act_max = '1;
		clear_window();
		p_good = 0; p_skip = 0; p_mism = 0;
		p_held = '0; p_charge = '0;
	endfunction

	function automatic bit plates_ok(logic ld, logic cd, logic [7:0] lp, logic [7:0] cp);
		return ld && cd && lp >= 8'd10 && lp <= 8'd18 && cp >= 8'd10 && cp <= 8'd18;
	endfunction

	// Charge and correction; returns 0 when the value cannot be applied
	function automatic bit new_actuator(output logic [31:0] nv);
		logic [63:0] avg;
		logic [127:0] q;
		longint err, gn, prod, corr, factor;
		logic [63:0] c, fhi, flo, val;
		avg = (p_fill != 0) ? 64'(p_sum) / 64'(p_fill) : 64'd0;
		q = ((128'(avg) * 128'd11543627) + 128'h8000_0000) >> 32;
		p_charge = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		err = longint'({32'd0, p_charge}) - longint'({32'd0, p_setpoint});
		gn = longint'(signed'(p_gain));
		prod = err * gn + (longint'(1) << 23);
		corr = prod >>> 24;
		if (corr > (longint'(1) << 24)) begin
			c = corr;
			corr = (c >> 24) * p_setpoint + (((c & 64'hFF_FFFF) * p_setpoint + 64'h80_0000) >> 24);
		end
		factor = (longint'(1) << 24) - corr;
		nv = '0;
		if (factor <= 0 || p_held == 0) return !(factor < 0 && p_held != 0);
		fhi = 64'(factor) >> 24;
		flo = 64'(factor) & 64'hFF_FFFF;
		if (fhi != 0 && 64'(p_held) > 64'hFFFF_FFFF / fhi) return 0;
		val = 64'(p_held) * fhi + ((64'(p_held) * flo + 64'h80_0000) >> 24);
		if (val > 64'hFFFF_FFFF) return 0;
		nv = val[31:0];
		return 1;
	endfunction

	function automatic result_t predict_pulse(item_t it);
		result_t r;
		status_t st;
		bit low_rd, ok;
		logic [31:0] nv;
		r.actuator_written = 1'b0;
		low_rd = 0;
		if (!plates_ok(it.laser_done, it.camera_done, it.laser_position, it.camera_position)) begin
			p_good = 0;
			st = ST_MOVING;
		end else if (!it.pulse_match) begin
			if (p_mism < 255) p_mism++;
			if (p_mism >= MISMATCH_LIMIT_DEF) begin
				p_mism = 0;
				st = ST_MISMATCH_LIMIT;
			end else st = ST_MISMATCH;
		end else begin
			p_mism = 0;
			if (it.electron_count > p_tmit_low) begin
				if (p_good < 255) p_good++;
				if (p_fill >= WIN) p_sum -= p_window[p_head];
				else p_fill++;
				p_window[p_head] = it.electron_count;
				p_sum += it.electron_count;
				p_head = (p_head + 1 >= WIN) ? 0 : p_head + 1;
			end else low_rd = 1;
			if (p_good >= GOOD_TARGET_DEF) begin
				p_good = 0;
				if (plates_ok(it.recheck_laser_done, it.recheck_camera_done,
						it.recheck_laser_position, it.recheck_camera_position)) begin
					ok = new_actuator(nv);
					if (!p_mode) begin
						nv = p_held;
						ok = 1;
					end
					if (ok && nv >= p_act_min && nv <= p_act_max) begin
						p_held = nv;
						r.actuator_written = 1'b1;
						p_skip = 0;
						st = ST_ACTED;
					end else st = ST_RANGE;
				end else begin
					if (p_skip < 255) p_skip++;
					clear_window();
					st = ST_SKIP;
					if (p_skip >= SKIP_LIMIT_DEF) begin
						if (!it.recheck_laser_done && it.recheck_camera_done) st = ST_LASER_FAULT;
						else if (it.recheck_laser_done && !it.recheck_camera_done)
							st = ST_CAMERA_FAULT;
						else if (!it.recheck_laser_done && !it.recheck_camera_done)
							st = ST_BOTH_FAULT;
					end
				end
			end else st = low_rd ? ST_LOW : ST_AVERAGING;
		end
		r.step_status = st;
		r.actuator_value = p_held;
		r.charge_state = p_charge;
		return r;
	endfunction

	// Driver: bursts of items with random gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				void'(pending_items.pop_front());
				expected_results.push_back(predict_pulse(in_ch.data));
			end
			if (gap_left > 0) gap_left <= gap_left - 1;
			if ((in_ch.valid && !in_ch.ready)) begin
				// hold the item until it is taken
			end else if (gap_left == 0 && pending_items.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_items[0];
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end else burst_left <= burst_left - 1;
			end else in_ch.valid <= 1'b0;
		end
	end

	// Monitor: stall pattern and result check
	logic [4:0] stall_phase = '0;
	logic [31:0] stall_mask = 32'hF0F3_0000;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 1'b1;
			if (stall_phase == 5'd31) stall_mask <= $urandom() & $urandom();
			out_ch.ready <= !stall_mask[stall_phase];
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %p", out_ch.data);
				end else begin
					result_t e;
					e = expected_results.pop_front();
					if (e !== out_ch.data) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p, got %p", e, out_ch.data);
					end
				end
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [35:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TMIT_LOW: p_tmit_low = val;
			REG_SETPOINT: p_setpoint = val[31:0];
			REG_GAIN: p_gain = val[31:0];
			REG_MODE: p_mode = val[0];
			REG_ACT_MIN: p_act_min = val[31:0];
			REG_ACT_MAX: p_act_max = val[31:0];
			REG_ACT_INIT: p_held = val[31:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || expected_results.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [7:0] good_pos();
		return 8'($urandom_range(10, 18));
	endfunction

	// Build a pulse; noisy picks random noise over a settled / well-formed one
	function automatic item_t make_pulse(bit noisy, logic [35:0] lo_thr);
		item_t it;
		it = item_t'(($bits(item_t))'({$urandom(), $urandom(), $urandom()}));
		if (!noisy) begin
			it.laser_done = 1; it.camera_done = 1;
			it.laser_position = good_pos(); it.camera_position = good_pos();
			it.pulse_match = ($urandom_range(0, 15) != 0);
			case ($urandom_range(0, 3))
				0: it.electron_count = {$urandom(), 4'($urandom())};
				1: it.electron_count = 36'($urandom_range(0, 1000000)) * 36'd50000;
				default: it.electron_count = 36'd6_000_000_000 + 36'($urandom_range(0, 500000000));
			endcase
			if ($urandom_range(0, 9) == 0) it.electron_count = lo_thr;
			if ($urandom_range(0, 7) != 0) begin
				it.recheck_laser_done = 1; it.recheck_camera_done = 1;
				it.recheck_laser_position = good_pos();
				it.recheck_camera_position = good_pos();
			end
		end
		return it;
	endfunction

	task automatic run_phase(int n, bit allow_noise);
		for (int i = 0; i < n; i++)
			pending_items.push_back(make_pulse(allow_noise && $urandom_range(0, 5) == 0, p_tmit_low));
		drain();
	endtask

	initial begin
		item_t it;
		reset_predictor();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: extremes, mismatch limit, low readings, a skip
		write_reg(REG_ACT_INIT, 36'h0010_0000);
		write_reg(REG_SETPOINT, 36'h0100_0000);
		write_reg(REG_GAIN, 36'h0080_0000);
		write_reg(REG_MODE, 36'd1);
		it = '0;
		pending_items.push_back(it);
		it = '1;
		pending_items.push_back(it);
		it.laser_done = 1; it.camera_done = 1; it.laser_position = 8'd10;
		it.camera_position = 8'd18; it.pulse_match = 0;
		for (int i = 0; i < 10; i++) pending_items.push_back(it);
		it.pulse_match = 1; it.electron_count = '0;
		pending_items.push_back(it);
		it.electron_count = '1;
		it.recheck_laser_done = 1; it.recheck_camera_done = 1;
		it.recheck_laser_position = 8'd9; it.recheck_camera_position = 8'd19;
		for (int i = 0; i < 10; i++) pending_items.push_back(it);
		drain();

		// Skip limit with each done-flag pattern
		for (int k = 0; k < 8; k++) begin
			it.recheck_laser_done = k[0]; it.recheck_camera_done = k[1];
			it.electron_count = 36'($urandom());
			for (int i = 0; i < 10; i++) pending_items.push_back(it);
		end
		drain();

		// Random phases through several register settings
		run_phase(80, 1);
		write_reg(REG_TMIT_LOW, 36'd5_000_000_000);
		write_reg(REG_SETPOINT, 36'h0_C000_0000);
		write_reg(REG_GAIN, 36'hFF00_0000);
		write_reg(REG_ACT_MIN, 36'h0000_1000);
		write_reg(REG_ACT_MAX, 36'h0FFF_FFFF);
		run_phase(80, 1);
		write_reg(REG_MODE, 36'd0);
		run_phase(50, 1);
		write_reg(REG_MODE, 36'd1);
		write_reg(REG_TMIT_LOW, 36'hF_FFFF_FFFF);
		run_phase(20, 1);
		write_reg(REG_TMIT_LOW, 36'd0);
		write_reg(REG_GAIN, 36'h7FFF_FFFF);
		write_reg(REG_SETPOINT, 36'hFFFF_FFFF);
		write_reg(REG_ACT_MIN, 36'd0);
		write_reg(REG_ACT_MAX, 36'hFFFF_FFFF);
		write_reg(REG_ACT_INIT, 36'hFFFF_FFFF);
		run_phase(60, 1);
		write_reg(REG_GAIN, 36'h8000_0000);
		write_reg(REG_SETPOINT, 36'd0);
		write_reg(REG_ACT_INIT, 36'h0001_0000);
		run_phase(60, 1);
		for (int k = 0; k < 4; k++) begin
			write_reg(REG_GAIN, {4'd0, $urandom() >> 6});
			write_reg(REG_SETPOINT, {4'd0, 32'h0100_0000 + ($urandom() >> 10)});
			write_reg(REG_ACT_INIT, {4'd0, $urandom()});
			run_phase(25, 1);
		end

		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
